// ----- rtl/thm_pkg.sv -----
// Shared types, opcodes, severity levels and the event code table of the
// timed hysteresis fault monitor. No dependencies.
package thm_pkg;

    localparam int EVT_MAX = 64;

    // Default sizes of the monitor.
    localparam int DEF_NUM_EVENTS = 33;
    localparam int DEF_NUM_TIMED  = 32;
    localparam int DEF_LOG_DEPTH  = 8;

    typedef enum logic [2:0] {
        OP_CHECK     = 3'd0,
        OP_SET       = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_MASK_SET  = 3'd3,
        OP_MASK_CLR  = 3'd4,
        OP_END_TICK  = 3'd5,
        OP_LATCH_CLR = 3'd6
    } opcode_t;

    localparam logic [2:0] LV_NONE = 3'd0;
    localparam logic [2:0] LV_MSG  = 3'd1;
    localparam logic [2:0] LV_WRN  = 3'd2;
    localparam logic [2:0] LV_FLT  = 3'd3;
    localparam logic [2:0] LV_PRT  = 3'd4;

    typedef struct packed {
        logic [15:0] code;
        logic [2:0]  level;
    } evt_info_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [5:0]         event_index;
        logic [2:0]         byte_index;
        logic signed [23:0] sample;
        logic signed [23:0] limit_level;
        logic signed [23:0] release_level;
        logic [15:0]        limit_hold;
        logic [15:0]        release_hold;
    } req_t;

    // Write port of the hold counter memory.
    typedef struct packed {
        logic        en;
        logic [5:0]  addr;
        logic [15:0] data;
    } cnt_wr_t;

    // Request to push an event's code into the log.
    typedef struct packed {
        logic       en;
        logic [5:0] evt;
    } log_req_t;

    function automatic evt_info_t evt_info(input logic [5:0] e);
        evt_info_t r;
        case (e)
            6'd0:    r = '{16'h0123, LV_FLT};
            6'd1:    r = '{16'h0223, LV_FLT};
            6'd2:    r = '{16'h0133, LV_FLT};
            6'd3:    r = '{16'h0233, LV_FLT};
            6'd4:    r = '{16'h0143, LV_FLT};
            6'd5:    r = '{16'h0243, LV_FLT};
            6'd6:    r = '{16'h0334, LV_PRT};
            6'd7:    r = '{16'h0122, LV_WRN};
            6'd8:    r = '{16'h0222, LV_WRN};
            6'd9:    r = '{16'h0132, LV_WRN};
            6'd10:   r = '{16'h0232, LV_WRN};
            6'd11:   r = '{16'h0142, LV_WRN};
            6'd12:   r = '{16'h0242, LV_WRN};
            6'd13:   r = '{16'h0332, LV_WRN};
            6'd14:   r = '{16'h0433, LV_FLT};
            6'd15:   r = '{16'h0533, LV_FLT};
            6'd16:   r = '{16'h0342, LV_WRN};
            6'd17:   r = '{16'h0114, LV_PRT};
            6'd18:   r = '{16'h0214, LV_PRT};
            6'd19:   r = '{16'h0314, LV_PRT};
            6'd20:   r = '{16'h0414, LV_PRT};
            6'd21:   r = '{16'h0514, LV_PRT};
            6'd22:   r = '{16'h0614, LV_FLT};
            6'd23:   r = '{16'h0714, LV_MSG};
            6'd24:   r = '{16'h0154, LV_PRT};
            6'd25:   r = '{16'h0254, LV_PRT};
            6'd26:   r = '{16'h0351, LV_MSG};
            6'd27:   r = '{16'h0454, LV_PRT};
            6'd28:   r = '{16'h0551, LV_MSG};
            6'd29:   r = '{16'h0654, LV_PRT};
            6'd30:   r = '{16'h0754, LV_PRT};
            6'd31:   r = '{16'h0851, LV_MSG};
            6'd32:   r = '{16'h0953, LV_FLT};
            default: r = '{16'h0000, LV_NONE};
        endcase
        return r;
    endfunction

    // Bit map of the events below num_events whose severity equals lvl.
    function automatic logic [EVT_MAX-1:0] level_mask(input logic [2:0] lvl,
                                                      input int num_events);
        logic [EVT_MAX-1:0] m;
        evt_info_t          inf;
        m = '0;
        for (int i = 0; i < EVT_MAX; i++)
        begin
            inf = evt_info(6'(i));
            if (i < num_events && inf.level == lvl)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/thm_req_if.sv -----
// Valid/ready channel that carries one monitor request per transaction.
// No dependencies.
interface thm_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [5:0]         event_index;
    logic [2:0]         byte_index;
    logic signed [23:0] sample;
    logic signed [23:0] limit_level;
    logic signed [23:0] release_level;
    logic [15:0]        limit_hold;
    logic [15:0]        release_hold;

    modport source (
        output valid, opcode, event_index, byte_index, sample, limit_level,
               release_level, limit_hold, release_hold,
        input  ready
    );
    modport sink (
        input  valid, opcode, event_index, byte_index, sample, limit_level,
               release_level, limit_hold, release_hold,
        output ready
    );
endinterface

// ----- rtl/thm_rsp_if.sv -----
// Valid/ready channel that carries one monitor result per transaction.
// No dependencies.
interface thm_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] fault_map;
    logic [63:0] latch_map;
    logic        event_active;
    logic [2:0]  worst_level;
    logic [15:0] newest_code;

    modport source (
        output valid, fault_map, latch_map, event_active, worst_level, newest_code,
        input  ready
    );
    modport sink (
        input  valid, fault_map, latch_map, event_active, worst_level, newest_code,
        output ready
    );
endinterface

// ----- rtl/thm_cnt_mem.sv -----
// Hold counter memory: one synchronous read port and one write port, with
// per-entry valid bits and write-to-read forwarding. Depends on thm_pkg.
module thm_cnt_mem
    import thm_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  cnt_wr_t       wr,
    output logic [15:0]   rd_count
);

    logic [15:0]      mem [DEPTH];
    logic [15:0]      rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             rd_valid_reg;
    logic             fwd_reg;
    logic [15:0]      fwd_data_reg;
    logic [AW-1:0]    wr_addr;
    logic             same_addr;

    assign wr_addr   = wr.addr[AW-1:0];
    assign same_addr = wr.en && (wr_addr == rd_addr);

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                fwd_reg      <= same_addr;
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign rd_count = fwd_reg ? fwd_data_reg : (rd_valid_reg ? rd_data_reg : 16'd0);

endmodule

// ----- rtl/thm_code_log.sv -----
// Error code log: a shift line of codes with the last logged event, which
// suppresses repeated pushes of the same event. Depends on thm_pkg.
module thm_code_log
    import thm_pkg::*;
#(
    parameter int LOG_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  log_req_t    req,
    output logic [15:0] head_next
);

    logic [15:0] log_reg [LOG_DEPTH];
    logic [5:0]  last_reg;
    logic        do_push;
    evt_info_t   info;

    // Right after reset the head of the log is zero, so the last logged
    // event resolves to event 0; the register simply starts there.
    assign info      = evt_info(req.evt);
    assign do_push   = req.en && (req.evt != last_reg);
    assign head_next = do_push ? info.code : log_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 6'd0;
            for (int i = 0; i < LOG_DEPTH; i++)
            begin
                log_reg[i] <= 16'd0;
            end
        end
        else if (do_push)
        begin
            last_reg   <= req.evt;
            log_reg[0] <= info.code;
            for (int i = 1; i < LOG_DEPTH; i++)
            begin
                log_reg[i] <= log_reg[i-1];
            end
        end
    end

endmodule

// ----- rtl/timed_hysteresis_fault_monitor_core.sv -----
// Channel  Dir  Interface    Content
// req      in   thm_req_if   opcode, event, byte, sample, levels, hold times
// rsp      out  thm_rsp_if   fault and latch maps, event state, worst level, code
//
// One request per cycle is sustained while results are taken. The hold
// counter memory is read at acceptance and written back as the update stage
// retires the request, with forwarding for back-to-back checks.
// Reset clears the fault and latch maps, sets all mask bits, and clears the
// counter valid bits and the code log at once. A stalled result holds the
// update stage, and the request side then stalls with it.
// Top level of the timed hysteresis fault monitor. Depends on thm_pkg,
// thm_req_if, thm_rsp_if, thm_cnt_mem and thm_code_log.
module timed_hysteresis_fault_monitor_core
    import thm_pkg::*;
#(
    parameter int NUM_EVENTS = DEF_NUM_EVENTS,
    parameter int NUM_TIMED  = DEF_NUM_TIMED,
    parameter int LOG_DEPTH  = DEF_LOG_DEPTH
) (
    input logic       clk,
    input logic       rst_n,
    thm_req_if.sink   req,
    thm_rsp_if.source rsp
);

    localparam int CNT_AW = (NUM_TIMED > 1) ? $clog2(NUM_TIMED) : 1;
    localparam logic [6:0] EVT_LIM   = 7'(NUM_EVENTS);
    localparam logic [6:0] TIMED_LIM = 7'(NUM_TIMED);
    localparam logic [63:0] KNOWN_MASK =
        (NUM_EVENTS >= 64) ? {64{1'b1}} : ((64'd1 << NUM_EVENTS) - 64'd1);
    localparam logic [63:0] MASK_PRT = level_mask(LV_PRT, NUM_EVENTS);
    localparam logic [63:0] MASK_FLT = level_mask(LV_FLT, NUM_EVENTS);
    localparam logic [63:0] MASK_WRN = level_mask(LV_WRN, NUM_EVENTS);
    localparam logic [63:0] MASK_MSG = level_mask(LV_MSG, NUM_EVENTS);

    logic        accept;
    logic        s1_go;
    logic        s1_valid_reg;
    req_t        s1_reg;
    logic [63:0] fault_reg, fault_next;
    logic [63:0] mask_reg, mask_next;
    logic [63:0] latch_reg, latch_next;
    logic        out_valid_reg;
    logic [63:0] out_fault_reg;
    logic [63:0] out_latch_reg;
    logic        out_active_reg;
    logic [15:0] out_code_reg;
    logic [15:0] rd_count;
    logic [15:0] head_next;
    cnt_wr_t     cnt_wr;
    log_req_t    log_req;
    logic [63:0] s1_bit;
    logic        s1_known;
    logic        s1_timed;
    logic        upper;
    logic        set_cond;
    logic        clr_cond;
    logic        cnt_zero;
    logic [15:0] cnt_dec;

    assign accept    = req.valid && req.ready;
    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_go;

    thm_cnt_mem #(
        .DEPTH (NUM_TIMED),
        .AW    (CNT_AW)
    ) u_cnt_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (req.event_index[CNT_AW-1:0]),
        .wr       (cnt_wr),
        .rd_count (rd_count)
    );

    thm_code_log #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_code_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (log_req),
        .head_next (head_next)
    );

    assign s1_bit   = 64'd1 << s1_reg.event_index;
    assign s1_known = {1'b0, s1_reg.event_index} < EVT_LIM;
    assign s1_timed = s1_known && ({1'b0, s1_reg.event_index} < TIMED_LIM);
    assign upper    = s1_reg.limit_level > s1_reg.release_level;
    assign set_cond = upper ? (s1_reg.sample > s1_reg.limit_level)
                            : (s1_reg.sample < s1_reg.limit_level);
    assign clr_cond = upper ? (s1_reg.sample < s1_reg.release_level)
                            : (s1_reg.sample > s1_reg.release_level);
    assign cnt_zero = (rd_count == 16'd0);
    assign cnt_dec  = rd_count - 16'd1;

    always_comb
    begin
        fault_next = fault_reg;
        mask_next  = mask_reg;
        latch_next = latch_reg;
        cnt_wr     = '0;
        log_req    = '0;
        cnt_wr.addr = s1_reg.event_index;
        log_req.evt = s1_reg.event_index;
        if (s1_go)
        begin
            case (s1_reg.opcode)
                OP_CHECK:
                begin
                    if (s1_timed)
                    begin
                        cnt_wr.en = 1'b1;
                        if ((fault_reg & s1_bit) == 64'd0)
                        begin
                            if (!set_cond)
                            begin
                                cnt_wr.data = s1_reg.limit_hold;
                            end
                            else if (cnt_zero)
                            begin
                                fault_next  = fault_reg | s1_bit;
                                log_req.en  = 1'b1;
                                cnt_wr.data = s1_reg.release_hold;
                            end
                            else
                            begin
                                cnt_wr.data = cnt_dec;
                            end
                        end
                        else
                        begin
                            if (!clr_cond)
                            begin
                                cnt_wr.data = s1_reg.release_hold;
                            end
                            else if (cnt_zero)
                            begin
                                fault_next  = fault_reg & ~s1_bit;
                                cnt_wr.data = s1_reg.limit_hold;
                            end
                            else
                            begin
                                cnt_wr.data = cnt_dec;
                            end
                        end
                    end
                end
                OP_SET:
                begin
                    if (s1_known)
                    begin
                        fault_next = fault_reg | s1_bit;
                        log_req.en = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    if (s1_known)
                    begin
                        fault_next = fault_reg & ~s1_bit;
                    end
                end
                OP_MASK_SET:
                begin
                    if (s1_known)
                    begin
                        mask_next = mask_reg | s1_bit;
                    end
                end
                OP_MASK_CLR:
                begin
                    if (s1_known)
                    begin
                        mask_next = mask_reg & ~s1_bit;
                    end
                end
                OP_END_TICK:
                begin
                    fault_next = fault_reg & mask_reg;
                    latch_next = latch_reg | (fault_reg & mask_reg);
                end
                OP_LATCH_CLR:
                begin
                    latch_next = latch_reg & ~(64'hFF << {s1_reg.byte_index, 3'b000});
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.opcode        <= req.opcode;
            s1_reg.event_index   <= req.event_index;
            s1_reg.byte_index    <= req.byte_index;
            s1_reg.sample        <= req.sample;
            s1_reg.limit_level   <= req.limit_level;
            s1_reg.release_level <= req.release_level;
            s1_reg.limit_hold    <= req.limit_hold;
            s1_reg.release_hold  <= req.release_hold;
        end
        if (s1_go)
        begin
            out_fault_reg  <= fault_next;
            out_latch_reg  <= latch_next;
            out_active_reg <= fault_next[s1_reg.event_index];
            out_code_reg   <= head_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fault_reg     <= '0;
            mask_reg      <= {64{1'b1}};
            latch_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            fault_reg <= fault_next;
            mask_reg  <= mask_next;
            latch_reg <= latch_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.fault_map    = out_fault_reg;
    assign rsp.latch_map    = out_latch_reg;
    assign rsp.event_active = out_active_reg;
    assign rsp.newest_code  = out_code_reg;
    assign rsp.worst_level  = ((out_fault_reg & MASK_PRT) != 64'd0) ? LV_PRT :
                              ((out_fault_reg & MASK_FLT) != 64'd0) ? LV_FLT :
                              ((out_fault_reg & MASK_WRN) != 64'd0) ? LV_WRN :
                              ((out_fault_reg & MASK_MSG) != 64'd0) ? LV_MSG : LV_NONE;

    // Architectural state moves only when the update stage retires a transaction.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_go |=> $stable(fault_reg) && $stable(mask_reg) && $stable(latch_reg))
        else $error("monitor state changed without a retiring transaction");

    // Events beyond the configured count never show up in the maps.
    a_known_only: assert property (@(posedge clk) disable iff (!rst_n)
        ((fault_reg & ~KNOWN_MASK) == 64'd0) && ((latch_reg & ~KNOWN_MASK) == 64'd0))
        else $error("fault or latch bit set for an unknown event");

    // An accepted transaction always occupies the update stage next cycle.
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction lost before the update stage");

endmodule

// ----- tb/tb_timed_hysteresis_fault_monitor_core.sv -----
// Self-checking testbench for timed_hysteresis_fault_monitor_core.
// Depends on thm_pkg, thm_req_if, thm_rsp_if and the monitor RTL; holds its own
// prediction of fault, mask, latch, hold counter and code log state.
`timescale 1ns / 1ps

module tb_timed_hysteresis_fault_monitor_core;
    import thm_pkg::*;

    localparam int MON_EVENTS  = 33;
    localparam int MON_TIMED   = 32;
    localparam int MON_LOG     = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_A     = 600;
    localparam int DRAIN_B     = 1200;
    localparam int RANDOM_GOAL = 1700;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int SAMPLE_MAX  = 8388607;
    localparam int SAMPLE_MIN  = -8388608;

    // Code and severity per event, listed from event 0 upward.
    localparam logic [16*MON_EVENTS-1:0] CODE_TABLE = {
        16'h0123, 16'h0223, 16'h0133, 16'h0233, 16'h0143, 16'h0243, 16'h0334, 16'h0122,
        16'h0222, 16'h0132, 16'h0232, 16'h0142, 16'h0242, 16'h0332, 16'h0433, 16'h0533,
        16'h0342, 16'h0114, 16'h0214, 16'h0314, 16'h0414, 16'h0514, 16'h0614, 16'h0714,
        16'h0154, 16'h0254, 16'h0351, 16'h0454, 16'h0551, 16'h0654, 16'h0754, 16'h0851,
        16'h0953
    };
    localparam logic [3*MON_EVENTS-1:0] LEVEL_TABLE = {
        LV_FLT, LV_FLT, LV_FLT, LV_FLT, LV_FLT, LV_FLT, LV_PRT, LV_WRN,
        LV_WRN, LV_WRN, LV_WRN, LV_WRN, LV_WRN, LV_WRN, LV_FLT, LV_FLT,
        LV_WRN, LV_PRT, LV_PRT, LV_PRT, LV_PRT, LV_PRT, LV_FLT, LV_MSG,
        LV_PRT, LV_PRT, LV_MSG, LV_PRT, LV_MSG, LV_PRT, LV_PRT, LV_MSG,
        LV_FLT
    };

    typedef struct packed {
        logic [63:0] fault_map;
        logic [63:0] latch_map;
        logic        event_active;
        logic [2:0]  worst_level;
        logic [15:0] newest_code;
    } monitor_result_t;

    logic clk;
    logic rst_n;

    thm_req_if req_ch ();
    thm_rsp_if rsp_ch ();

    timed_hysteresis_fault_monitor_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted block state.
    logic [63:0] fault_bits;
    logic [63:0] mask_bits;
    logic [63:0] latched_bits;
    logic [15:0] hold_count [0:MON_TIMED-1];
    logic [15:0] code_log [0:MON_LOG-1];
    int          last_logged;

    req_t            pending_items [$];
    monitor_result_t expected_results [$];

    int  sent_count;
    int  accepted_count;
    int  result_count;
    int  mismatches;
    int  cycles;
    int  checks_seen;
    int  codes_logged;
    int  hysteresis_clears;
    logic req_taken;

    req_t            seen_item;
    monitor_result_t predicted;
    monitor_result_t oldest;

    always #10 clk = ~clk;

    function automatic logic [15:0] code_of(input int e);
        return CODE_TABLE[16*(MON_EVENTS-1-e) +: 16];
    endfunction

    function automatic logic [2:0] level_of(input int e);
        return LEVEL_TABLE[3*(MON_EVENTS-1-e) +: 3];
    endfunction

    function automatic int clamp24(input int v);
        if (v > SAMPLE_MAX)
        begin
            return SAMPLE_MAX;
        end
        if (v < SAMPLE_MIN)
        begin
            return SAMPLE_MIN;
        end
        return v;
    endfunction

    function automatic req_t make_item(input logic [2:0] op, input int e, input int b,
                                       input int s, input int lim, input int rel,
                                       input int lh, input int rh);
        req_t it;
        it.opcode        = op;
        it.event_index   = 6'(e);
        it.byte_index    = 3'(b);
        it.sample        = 24'(s);
        it.limit_level   = 24'(lim);
        it.release_level = 24'(rel);
        it.limit_hold    = 16'(lh);
        it.release_hold  = 16'(rh);
        return it;
    endfunction

    // Pushes an event's code unless it was the last one logged. The first push
    // after reset resolves which event the head of the log belongs to.
    task automatic log_fault_code(input int e);
        if (last_logged == MON_EVENTS)
        begin
            if (code_log[0] == 16'h0000)
            begin
                last_logged = 0;
            end
            else
            begin
                for (int i = 0; i < MON_EVENTS; i++)
                begin
                    if (last_logged == MON_EVENTS && code_of(i) == code_log[0])
                    begin
                        last_logged = i;
                    end
                end
            end
        end
        if (e != last_logged)
        begin
            last_logged = e;
            for (int i = MON_LOG - 1; i > 0; i--)
            begin
                code_log[i] = code_log[i-1];
            end
            code_log[0] = code_of(e);
            codes_logged++;
        end
    endtask

    task automatic apply_hysteresis(input req_t it);
        int                 e;
        logic signed [23:0] s;
        logic signed [23:0] lim;
        logic signed [23:0] rel;
        logic               upper;
        logic               past;
        e     = it.event_index;
        s     = it.sample;
        lim   = it.limit_level;
        rel   = it.release_level;
        upper = lim > rel;
        checks_seen++;
        if (!fault_bits[e])
        begin
            past = upper ? (s > lim) : (s < lim);
            if (!past)
            begin
                hold_count[e] = it.limit_hold;
            end
            else if (hold_count[e] == 16'd0)
            begin
                fault_bits[e] = 1'b1;
                log_fault_code(e);
                hold_count[e] = it.release_hold;
            end
            else
            begin
                hold_count[e] = hold_count[e] - 16'd1;
            end
        end
        else
        begin
            past = upper ? (s < rel) : (s > rel);
            if (!past)
            begin
                hold_count[e] = it.release_hold;
            end
            else if (hold_count[e] == 16'd0)
            begin
                fault_bits[e] = 1'b0;
                hold_count[e] = it.limit_hold;
                hysteresis_clears++;
            end
            else
            begin
                hold_count[e] = hold_count[e] - 16'd1;
            end
        end
    endtask

    task automatic step_monitor(input req_t it, output monitor_result_t res);
        int  e;
        logic known;
        logic [2:0] worst;
        e     = it.event_index;
        known = e < MON_EVENTS;
        case (it.opcode)
            OP_CHECK:
            begin
                if (known && e < MON_TIMED)
                begin
                    apply_hysteresis(it);
                end
            end
            OP_SET:
            begin
                if (known)
                begin
                    fault_bits[e] = 1'b1;
                    log_fault_code(e);
                end
            end
            OP_CLEAR:
            begin
                if (known)
                begin
                    fault_bits[e] = 1'b0;
                end
            end
            OP_MASK_SET:
            begin
                if (known)
                begin
                    mask_bits[e] = 1'b1;
                end
            end
            OP_MASK_CLR:
            begin
                if (known)
                begin
                    mask_bits[e] = 1'b0;
                end
            end
            OP_END_TICK:
            begin
                fault_bits   = fault_bits & mask_bits;
                latched_bits = latched_bits | fault_bits;
            end
            OP_LATCH_CLR:
            begin
                latched_bits = latched_bits & ~(64'hFF << (8 * it.byte_index));
            end
            default:
            begin
            end
        endcase
        worst = LV_NONE;
        for (int i = 0; i < MON_EVENTS; i++)
        begin
            if (fault_bits[i] && level_of(i) > worst)
            begin
                worst = level_of(i);
            end
        end
        res.fault_map    = fault_bits;
        res.latch_map    = latched_bits;
        res.event_active = fault_bits[e];
        res.worst_level  = worst;
        res.newest_code  = code_log[0];
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Requests are driven on the falling edge; a transaction that is not taken
    // stays on the bus unchanged.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (pending_items.size() != 0
                    && !((sent_count == DRAIN_A || sent_count == DRAIN_B)
                         && expected_results.size() != 0)
                    && $urandom_range(0, 99) >= (sent_count < DRAIN_A ? 6 :
                                                 sent_count < DRAIN_B ? 82 : 0))
                begin
                    req_t it;
                    it = pending_items.pop_front();
                    req_ch.opcode        <= it.opcode;
                    req_ch.event_index   <= it.event_index;
                    req_ch.byte_index    <= it.byte_index;
                    req_ch.sample        <= it.sample;
                    req_ch.limit_level   <= it.limit_level;
                    req_ch.release_level <= it.release_level;
                    req_ch.limit_hold    <= it.limit_hold;
                    req_ch.release_hold  <= it.release_hold;
                    req_ch.valid         <= 1'b1;
                    sent_count++;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= $urandom_range(0, 99) >= (sent_count < DRAIN_A ? 82 :
                                                      sent_count < DRAIN_B ? 6 : 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                seen_item.opcode        = req_ch.opcode;
                seen_item.event_index   = req_ch.event_index;
                seen_item.byte_index    = req_ch.byte_index;
                seen_item.sample        = req_ch.sample;
                seen_item.limit_level   = req_ch.limit_level;
                seen_item.release_level = req_ch.release_level;
                seen_item.limit_hold    = req_ch.limit_hold;
                seen_item.release_hold  = req_ch.release_hold;
                step_monitor(seen_item, predicted);
                expected_results.push_back(predicted);
                accepted_count++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction arrived with nothing expected");
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    compare_field("fault_map", oldest.fault_map, rsp_ch.fault_map);
                    compare_field("latch_map", oldest.latch_map, rsp_ch.latch_map);
                    compare_field("event_active", oldest.event_active, rsp_ch.event_active);
                    compare_field("worst_level", oldest.worst_level, rsp_ch.worst_level);
                    compare_field("newest_code", oldest.newest_code, rsp_ch.newest_code);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int count;
        int kind;
        int e;
        int centre;
        int gap;
        int lim;
        int rel;
        int lh;
        int rh;
        int s;
        int runs;
        logic upper;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_CHECK;
        req_ch.event_index   = '0;
        req_ch.byte_index    = '0;
        req_ch.sample        = '0;
        req_ch.limit_level   = '0;
        req_ch.release_level = '0;
        req_ch.limit_hold    = '0;
        req_ch.release_hold  = '0;
        rsp_ch.ready         = 1'b0;
        req_taken            = 1'b0;
        sent_count           = 0;
        accepted_count       = 0;
        result_count         = 0;
        mismatches           = 0;
        cycles               = 0;
        checks_seen          = 0;
        codes_logged         = 0;
        hysteresis_clears    = 0;

        fault_bits   = '0;
        mask_bits    = '1;
        latched_bits = '0;
        for (int i = 0; i < MON_TIMED; i++)
        begin
            hold_count[i] = '0;
        end
        for (int i = 0; i < MON_LOG; i++)
        begin
            code_log[i] = '0;
        end
        last_logged = MON_EVENTS;

        // Directed part. A set of event 0 straight after reset is not logged,
        // since the empty log head resolves to event 0.
        pending_items.push_back(make_item(OP_SET, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SET, 32, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SET, 63, 7, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SET, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SET, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_END_TICK, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_MASK_CLR, 32, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_END_TICK, 32, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_MASK_SET, 32, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_MASK_CLR, 40, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_LATCH_CLR, 32, 4, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_LATCH_CLR, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_LATCH_CLR, 0, 7, 0, 0, 0, 0, 0));
        // Upper channel at the extremes of the sample range.
        pending_items.push_back(make_item(OP_CHECK, 3, 0, SAMPLE_MAX, SAMPLE_MAX - 1,
                                          SAMPLE_MIN, 0, 65535));
        pending_items.push_back(make_item(OP_CHECK, 3, 0, SAMPLE_MIN, SAMPLE_MAX - 1,
                                          SAMPLE_MIN + 1, 0, 65535));
        pending_items.push_back(make_item(OP_CHECK, 3, 0, SAMPLE_MIN, SAMPLE_MAX - 1,
                                          SAMPLE_MIN, 0, 65535));
        // Lower channel: sets at once, then clears on the next release sample.
        pending_items.push_back(make_item(OP_CHECK, 4, 0, SAMPLE_MIN, -100, 100, 65535, 0));
        pending_items.push_back(make_item(OP_CHECK, 4, 0, SAMPLE_MAX, -100, 100, 65535, 0));
        // Equal levels watch the lower side; a sample on the level does not set the fault.
        pending_items.push_back(make_item(OP_CHECK, 31, 0, 0, 0, 0, 5, 5));
        pending_items.push_back(make_item(OP_CHECK, 32, 0, SAMPLE_MAX, 0, -1, 0, 0));
        pending_items.push_back(make_item(OP_CHECK, 63, 0, SAMPLE_MAX, 0, -1, 0, 0));
        pending_items.push_back(make_item(OP_UNUSED, 17, 3, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SET, 17, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SET, 23, 0, 0, 0, 0, 0, 0));

        count = 0;
        while (count < RANDOM_GOAL)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // One channel goes past its limit and comes back past release.
                e      = $urandom_range(0, MON_TIMED - 1);
                centre = $signed(24'($urandom));
                centre = centre / 2;
                gap    = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1000);
                upper  = (gap != 0) && $urandom_range(0, 1);
                lim    = clamp24(upper ? centre + gap : centre - gap);
                rel    = clamp24(upper ? centre - gap : centre + gap);
                lh     = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 3);
                rh     = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 3);
                runs   = $urandom_range(2, 12);
                for (int k = 0; k < runs; k++)
                begin
                    case ($urandom_range(0, 9))
                        0:       s = centre;
                        1:       s = lim;
                        2:       s = $signed(24'($urandom));
                        default:
                        begin
                            if (k < runs / 2)
                            begin
                                s = upper ? lim + $urandom_range(1, 50)
                                          : lim - $urandom_range(1, 50);
                            end
                            else
                            begin
                                s = upper ? rel - $urandom_range(1, 50)
                                          : rel + $urandom_range(1, 50);
                            end
                        end
                    endcase
                    pending_items.push_back(make_item(OP_CHECK, e, $urandom_range(0, 7),
                                                      clamp24(s), lim, rel, lh, rh));
                    count++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    pending_items.push_back(make_item(OP_END_TICK, e, 0, 0, 0, 0, 0, 0));
                    count++;
                end
            end
            else if (kind < 82)
            begin
                e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, MON_EVENTS - 1);
                case ($urandom_range(0, 3))
                    0:       pending_items.push_back(make_item(OP_SET, e, 0, 0, 0, 0, 0, 0));
                    1:       pending_items.push_back(make_item(OP_CLEAR, e, 0, 0, 0, 0, 0, 0));
                    2:       pending_items.push_back(make_item(OP_MASK_SET, e, 0, 0, 0, 0, 0, 0));
                    default: pending_items.push_back(make_item(OP_MASK_CLR, e, 0, 0, 0, 0, 0, 0));
                endcase
                count++;
            end
            else if (kind < 90)
            begin
                pending_items.push_back(make_item(OP_END_TICK, $urandom_range(0, 63), 0,
                                                  0, 0, 0, 0, 0));
                count++;
            end
            else if (kind < 95)
            begin
                pending_items.push_back(make_item(OP_LATCH_CLR, $urandom_range(0, 63),
                                                  $urandom_range(0, 7), 0, 0, 0, 0, 0));
                count++;
            end
            else
            begin
                // Fully random transaction, unused opcode included.
                pending_items.push_back(make_item(3'($urandom_range(0, 7)),
                                                  $urandom_range(0, 63),
                                                  $urandom_range(0, 7),
                                                  $signed(24'($urandom)),
                                                  $signed(24'($urandom)),
                                                  $signed(24'($urandom)),
                                                  $urandom_range(0, 65535),
                                                  $urandom_range(0, 65535)));
                count++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(pending_items.size() == 0 && !req_ch.valid
                 && expected_results.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Run covered %0d transactions, %0d results, %0d channel checks,",
                 accepted_count, result_count, checks_seen);
        $display("%0d codes logged and %0d faults released through hysteresis.",
                 codes_logged, hysteresis_clears);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
